[src/ffbp_pkg.sv]
package ffbp_pkg;

    // Pool geometry and field widths
    localparam int POOL_ENTRIES = 32;
    localparam int COUNT_W      = 6;
    localparam int BYTES_W      = 24;
    localparam int SIZE_W       = 32;
    localparam int HANDLE_W     = 32;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [COUNT_W-1:0] POOL_CAP     = COUNT_W'(POOL_ENTRIES);
    localparam logic [COUNT_W-1:0] LIMIT_RESET  = COUNT_W'(20);
    localparam logic [BYTES_W-1:0] BUDGET_RESET = BYTES_W'(8192);

    // Register index, taken from paddr[2]
    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_BUDGET = 1'b1;

    // Operation codes
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_GROW    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // One pooled buffer
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } t_ent;

    // Signals passed from cell to cell along the row
    typedef struct packed {
        logic found;
        t_ent take;
        t_ent last;
    } t_chain;

    // Write command into one cell
    typedef struct packed {
        logic en;
        t_ent ent;
    } t_wr;

endpackage

[src/first_fit_buffer_pool.sv]
// An accepted input beat is compared in the cells, then passes the select, adjust and
// update states; the result beat goes valid on the commit in update, which waits for a
// free output. A grow miss doubles the size instead until it covers the request. One item
// is in work at a time, set by the compare / select / adjust / commit pass over the cells.
// Reset: synchronous active low; clears the entry count, pooled bytes, control state
// and output valid, and loads entry_limit 20 and byte_budget 8192. No clearing pass.
module first_fit_buffer_pool (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input beat
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [95:0]                  s_axis_tdata,  // req_size, buf_handle, buf_size
    input  logic [1:0]                   s_axis_tuser,  // op
    // result beat
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_handle, out_size, count_now, bytes_now, zero pad
    output logic [95:0]                  m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,  // from_pool, old_kept
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffbp_pkg::APB_AW-1:0]  paddr,
    input  logic [ffbp_pkg::APB_DW-1:0]  pwdata,
    output logic [ffbp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import ffbp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEL  = 5'b00010,
        S_ADJ  = 5'b00100,
        S_UPD  = 5'b01000,
        S_DBL  = 5'b10000
    } t_state;

    t_state r_state;
    logic [1:0]            r_op;
    logic [SIZE_W-1:0]     r_req;
    logic [HANDLE_W-1:0]   r_bh;
    logic [SIZE_W-1:0]     r_bs;
    logic [POOL_ENTRIES-1:0] r_sel;
    logic                  r_any;
    t_ent                  r_take;
    t_ent                  r_last;
    logic [COUNT_W-1:0]    r_cnt1;
    logic [BYTES_W-1:0]    r_bytes1;
    logic [SIZE_W-1:0]     r_ns;
    logic [COUNT_W-1:0]    r_count;
    logic [BYTES_W-1:0]    r_bytes;
    logic [COUNT_W-1:0]    r_limit;
    logic [BYTES_W-1:0]    r_budget;
    logic                  r_m_valid;
    logic                  r_from_pool;
    logic                  r_old_kept;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic [SIZE_W-1:0]     r_out_size;

    logic                  in_beat;
    logic                  out_free;
    logic                  cfg_wr;
    logic                  take_ok;
    logic                  give_req;
    logic                  give_ok;
    logic [COUNT_W-1:0]    lim;
    logic [SIZE_W:0]       give_sum;
    logic                  commit;
    logic                  dbl_done;
    logic                  out_load;
    logic [POOL_ENTRIES-1:0] cell_sel;
    logic [POOL_ENTRIES-1:0] cell_valid;
    logic [POOL_ENTRIES-1:0] cell_last;
    t_chain                chain [POOL_ENTRIES+1];
    t_wr                   cell_wr [POOL_ENTRIES];

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_m_valid || m_axis_tready;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BUDGET) ? APB_DW'(r_budget) : APB_DW'(r_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_budget <= BUDGET_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BUDGET) begin
                r_budget <= pwdata[BYTES_W-1:0];
            end else begin
                r_limit <= pwdata[COUNT_W-1:0];
            end
        end
    end

    // Cell row
    assign chain[0] = '0;

    genvar j;
    generate
        for (j = 0; j < POOL_ENTRIES; j++) begin : g_cell
            assign cell_valid[j] = (COUNT_W'(j) < r_count);
            assign cell_last[j]  = (r_count == COUNT_W'(j + 1));

            // Give lands at the new tail; a take refills its slot from the old tail
            always_comb begin
                cell_wr[j].en  = commit && ((give_ok && (r_cnt1 == COUNT_W'(j))) ||
                                 (take_ok && r_sel[j] && (r_cnt1 != COUNT_W'(j))));
                cell_wr[j].ent = (give_ok && (r_cnt1 == COUNT_W'(j))) ?
                                 t_ent'{handle: r_bh, size: r_bs} : r_last;
            end

            ffbp_cell u_cell (
                .i_clk   (i_clk),
                .i_cap   (in_beat),
                .i_req   (s_axis_tdata[SIZE_W-1:0]),
                .i_valid (cell_valid[j]),
                .i_last  (cell_last[j]),
                .i_chain (chain[j]),
                .o_chain (chain[j+1]),
                .o_sel   (cell_sel[j]),
                .i_wr    (cell_wr[j])
            );
        end
    endgenerate

    // Commit arithmetic
    always_comb begin
        take_ok  = r_any && ((r_op == OP_ACQUIRE) || (r_op == OP_GROW));
        give_req = (r_op == OP_RELEASE) || ((r_op == OP_GROW) && r_any);
        lim      = (r_limit > POOL_CAP) ? POOL_CAP : r_limit;
        give_sum = (SIZE_W+1)'(r_bytes1) + (SIZE_W+1)'(r_bs);
        give_ok  = give_req && (r_cnt1 < lim) && (give_sum < (SIZE_W+1)'(r_budget));
        commit   = (r_state == S_UPD) && out_free && !((r_op == OP_GROW) && !r_any);
        dbl_done = (r_ns >= r_req) || r_ns[SIZE_W-1];
        out_load = commit || ((r_state == S_DBL) && dbl_done && out_free);
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_bytes   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // raise the result on a finished item, drop it once taken
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_state <= S_ADJ;
                end
                S_ADJ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if ((r_op == OP_GROW) && !r_any) begin
                        r_state <= S_DBL;
                    end else if (commit) begin
                        r_count   <= give_ok ? r_cnt1 + COUNT_W'(1) : r_cnt1;
                        r_bytes   <= give_ok ? give_sum[BYTES_W-1:0] : r_bytes1;
                        r_state   <= S_IDLE;
                    end
                end
                S_DBL: begin
                    if (dbl_done && out_free) begin
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // hold the accepted beat
        if (in_beat) begin
            r_op  <= s_axis_tuser;
            r_req <= s_axis_tdata[SIZE_W-1:0];
            r_bh  <= s_axis_tdata[SIZE_W+HANDLE_W-1:SIZE_W];
            r_bs  <= s_axis_tdata[2*SIZE_W+HANDLE_W-1:SIZE_W+HANDLE_W];
        end
        // collect the first fit and the tail entry from the row
        if (r_state == S_SEL) begin
            r_sel  <= cell_sel;
            r_any  <= chain[POOL_ENTRIES].found;
            r_take <= chain[POOL_ENTRIES].take;
            r_last <= chain[POOL_ENTRIES].last;
        end
        // count and bytes after the take
        if (r_state == S_ADJ) begin
            r_cnt1   <= take_ok ? r_count - COUNT_W'(1) : r_count;
            r_bytes1 <= take_ok ? r_bytes - r_take.size[BYTES_W-1:0] : r_bytes;
        end
        // start the size doubling from the old size, zero counted as one
        if ((r_state == S_UPD) && (r_op == OP_GROW) && !r_any) begin
            r_ns <= (r_bs == '0) ? SIZE_W'(1) : r_bs;
        end
        if ((r_state == S_DBL) && !dbl_done) begin
            r_ns <= r_ns << 1;
        end
        // result fields
        if (commit) begin
            r_from_pool  <= take_ok;
            r_out_handle <= take_ok ? r_take.handle : '0;
            r_out_size   <= take_ok ? r_take.size :
                            ((r_op == OP_ACQUIRE) ? r_req : '0);
            r_old_kept   <= give_ok;
        end
        if ((r_state == S_DBL) && dbl_done && out_free) begin
            r_from_pool  <= 1'b0;
            r_out_handle <= '0;
            r_out_size   <= (r_ns >= r_req) ? r_ns : '1;
            r_old_kept   <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_bytes, r_count, r_out_size, r_out_handle};
    assign m_axis_tuser  = {r_old_kept, r_from_pool};

endmodule

[src/ffbp_cell.sv]
module ffbp_cell (
    input  logic                          i_clk,
    input  logic                          i_cap,
    input  logic [ffbp_pkg::SIZE_W-1:0]   i_req,
    input  logic                          i_valid,
    input  logic                          i_last,
    input  ffbp_pkg::t_chain              i_chain,
    output ffbp_pkg::t_chain              o_chain,
    output logic                          o_sel,
    input  ffbp_pkg::t_wr                 i_wr
);
    import ffbp_pkg::*;

    t_ent r_ent;
    logic r_hit;

    // Capture the fit compare when a beat is accepted; take writes
    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_hit <= i_valid && (r_ent.size >= i_req);
        end
        if (i_wr.en) begin
            r_ent <= i_wr.ent;
        end
    end

    // First hit wins: claim it only if no lower cell has
    assign o_sel = r_hit && !i_chain.found;

    // Pass found flag and collected entries on to the next cell
    always_comb begin
        o_chain.found = i_chain.found | r_hit;
        o_chain.take  = i_chain.take | (o_sel ? r_ent : '0);
        o_chain.last  = i_chain.last | (i_last ? r_ent : '0);
    end

endmodule

[src/ffbp_checker.sv]
module ffbp_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [95:0]                  m_axis_tdata,
    input  logic [1:0]                   m_axis_tuser
);
    import ffbp_pkg::*;

    // Pool never reports more entries than it has slots
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[69:64] <= POOL_CAP))
        else $error("count_now above pool capacity");

    // A result not served from the pool carries no handle
    a_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == '0))
        else $error("handle given without a pool hit");

    // One item in work at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind first_fit_buffer_pool ffbp_checker u_ffbp_checker (.*);
